// ----- design/ibmm_pkg.sv -----
// Package for the indexed Barrett modular multiply pair.
// Holds operation and register codes, the queue entry type and sizing constants.
// No dependencies.
package ibmm_pkg;

  // default number of factor words in the table
  localparam int unsigned TableDepth = 4096;
  // entries in the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // item operation codes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODULUS = 2'd0,
    CFG_BARRETT = 2'd1,
    CFG_MASK    = 2'd2
  } cfg_idx_e;

  // configuration register contents
  typedef struct packed {
    logic [31:0] modulus;
    logic [63:0] barrett_factor;
    logic [11:0] elim_mask;
  } cfg_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic        finish;
    logic [31:0] value_zero;
    logic [31:0] value_one;
    logic [31:0] factor_zero;
    logic [31:0] factor_one;
    logic        last;
  } item_t;

endpackage

// ----- design/ibmm_if.sv -----
// Request and result channel interfaces of the modular multiply pair.
// Depends on nothing; valid/ready handshake with the payload fields.
interface ibmm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] index;
  logic [31:0] load_word;
  logic [31:0] value_zero;
  logic [31:0] value_one;
  logic        last_item;

  modport source (output valid, operation, index, load_word, value_zero, value_one,
                  last_item, input ready);
  modport sink (input valid, operation, index, load_word, value_zero, value_one,
                last_item, output ready);
endinterface

interface ibmm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_zero;
  logic [31:0] result_one;
  logic [31:0] pair_sum;
  logic        last_out;

  modport source (output valid, result_zero, result_one, pair_sum, last_out, input ready);
  modport sink (input valid, result_zero, result_one, pair_sum, last_out, output ready);
endinterface

// ----- design/ibmm_front.sv -----
// Front end: accepts requests, writes loads into the factor table and reads both factors.
// Depends on ibmm_pkg and ibmm_in_if.
module ibmm_front #(
  parameter int unsigned TABLE_DEPTH = ibmm_pkg::TableDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ibmm_in_if.sink         in_i,
  input  logic [11:0]     elim_mask_i,
  output logic            push_valid_o,
  output ibmm_pkg::item_t push_item_o,
  input  logic            push_ready_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // reciprocal of the depth scaled by 2^24, for wrapping 12-bit addresses
  localparam logic [24:0] Recip = 25'((64'd1 << 24) / TABLE_DEPTH);

  // address modulo table depth: reciprocal estimate, then one correction
  function automatic logic [AW-1:0] wrap_addr(input logic [11:0] a);
    logic [36:0] prod;
    logic [11:0] quot;
    logic [31:0] rem;
    prod = 37'(a) * 37'(Recip);
    quot = prod[35:24];
    rem  = 32'(a) - 32'(quot) * 32'(TABLE_DEPTH);
    if (rem >= 32'(TABLE_DEPTH)) begin
      rem = rem - 32'(TABLE_DEPTH);
    end
    return rem[AW-1:0];
  endfunction

  logic [31:0]   mem_q [TABLE_DEPTH];
  logic          accept, is_load, is_work;
  logic [AW-1:0] addr_zero, addr_one;
  logic          hold_v_q, hold_v_d;
  logic          finish_q, last_q;
  logic [31:0]   v0_q, v1_q, f0_q, f1_q;

  assign in_i.ready = !hold_v_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_load    = accept && (in_i.operation == ibmm_pkg::OP_LOAD);
  assign is_work    = accept && ((in_i.operation == ibmm_pkg::OP_UPDATE) ||
                                 (in_i.operation == ibmm_pkg::OP_FINISH));
  assign addr_zero  = wrap_addr(in_i.index);
  assign addr_one   = wrap_addr(in_i.index | elim_mask_i);

  // factor table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      mem_q[addr_zero] <= in_i.load_word;
    end
    if (is_work) begin
      f0_q <= mem_q[addr_zero];
      f1_q <= mem_q[addr_one];
    end
  end

  // holding stage valid
  always_comb begin
    hold_v_d = hold_v_q;
    if (is_work) begin
      hold_v_d = 1'b1;
    end else if (push_ready_i) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  // holding stage payload
  always_ff @(posedge clk_i) begin
    if (is_work) begin
      finish_q <= (in_i.operation == ibmm_pkg::OP_FINISH);
      v0_q     <= in_i.value_zero;
      v1_q     <= in_i.value_one;
      last_q   <= in_i.last_item;
    end
  end

  assign push_valid_o             = hold_v_q;
  assign push_item_o.finish       = finish_q;
  assign push_item_o.value_zero   = v0_q;
  assign push_item_o.value_one    = v1_q;
  assign push_item_o.factor_zero  = f0_q;
  assign push_item_o.factor_one   = f1_q;
  assign push_item_o.last         = last_q;

endmodule

// ----- design/ibmm_queue.sv -----
// Short queue between front and back of the modular multiply pair.
// Depends on ibmm_pkg (item type, queue depth).
module ibmm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ibmm_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ibmm_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);

  localparam int unsigned QD = ibmm_pkg::QueueDepth;
  localparam int unsigned PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW = $clog2(QD + 1);

  ibmm_pkg::item_t entry_q [QD];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(QD));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  // fill level stays within bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(QD))
    else $error("queue fill level beyond depth");
  // an entry popped while the queue held one leaves it empty unless refilled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == CW'(1) && pop && !push) |=> !pop_valid_o)
    else $error("queue not empty after last entry popped");
  // a full queue with no pop stays full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!push_ready_o && !pop) |=> !push_ready_o)
    else $error("full queue lost an entry");

endmodule

// ----- design/ibmm_back.sv -----
// Back end: six-stage Barrett multiply-reduce pipeline for both sides, plus finish sums.
// Depends on ibmm_pkg and ibmm_out_if.
module ibmm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  ibmm_pkg::item_t pop_item_i,
  output logic            pop_ready_o,
  input  logic [31:0]     modulus_i,
  input  logic [63:0]     barrett_i,
  ibmm_out_if.source      out_o
);

  // per-stage control that rides along with the data
  typedef struct packed {
    logic        finish;
    logic        last;
    logic [32:0] sum;
  } ctl_t;

  ctl_t              c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic              c1_v_q, c2_v_q, c3_v_q, c4_v_q, c5_v_q, c6_v_q;
  logic [1:0][63:0]  p1_q, p2_q, p3_q, p4_q;
  logic [1:0][63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [1:0][63:0]  q_q, qlo_m_q, r_q;
  logic [1:0][31:0]  qhi_m_q, res_q;
  logic [31:0]       sum_q;
  logic              adv;
  logic [1:0][33:0]  mid;
  logic [1:0][63:0]  qhi_full, r_sub;

  // whole pipeline moves when the output register is free
  assign adv         = !c6_v_q || out_o.ready;
  assign pop_ready_o = adv;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      mid[s]      = 34'(ll_q[s][63:32]) + 34'(lh_q[s][31:0]) + 34'(hl_q[s][31:0]);
      qhi_full[s] = 64'(qhi_m_q[s]) << 32;
      r_sub[s]    = p4_q[s] - (qlo_m_q[s] + qhi_full[s]);
    end
  end

  // control valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
      c4_v_q <= 1'b0;
      c5_v_q <= 1'b0;
      c6_v_q <= 1'b0;
    end else if (adv) begin
      c1_v_q <= pop_valid_i;
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
      c4_v_q <= c3_v_q;
      c5_v_q <= c4_v_q;
      c6_v_q <= c5_v_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: value times factor, pair sum
      c1_q.finish <= pop_item_i.finish;
      c1_q.last   <= pop_item_i.last;
      c1_q.sum    <= 33'(pop_item_i.value_zero) + 33'(pop_item_i.value_one);
      p1_q[0]     <= 64'(pop_item_i.value_zero) * 64'(pop_item_i.factor_zero);
      p1_q[1]     <= 64'(pop_item_i.value_one) * 64'(pop_item_i.factor_one);
      {c2_q.finish, c2_q.last, c2_q.sum} <= {c1_q.finish, c1_q.last, c1_q.sum};
      {c3_q.finish, c3_q.last, c3_q.sum} <= {c2_q.finish, c2_q.last, c2_q.sum};
      {c4_q.finish, c4_q.last, c4_q.sum} <= {c3_q.finish, c3_q.last, c3_q.sum};
      {c5_q.finish, c5_q.last, c5_q.sum} <= {c4_q.finish, c4_q.last, c4_q.sum};
      {c6_q.finish, c6_q.last, c6_q.sum} <= {c5_q.finish, c5_q.last, c5_q.sum};
      for (int s = 0; s < 2; s++) begin
        // stage 2: partial products of value times reciprocal
        ll_q[s] <= 64'(p1_q[s][31:0])  * 64'(barrett_i[31:0]);
        lh_q[s] <= 64'(p1_q[s][31:0])  * 64'(barrett_i[63:32]);
        hl_q[s] <= 64'(p1_q[s][63:32]) * 64'(barrett_i[31:0]);
        hh_q[s] <= 64'(p1_q[s][63:32]) * 64'(barrett_i[63:32]);
        p2_q[s] <= p1_q[s];
        // stage 3: high half of the 128-bit product
        q_q[s]  <= hh_q[s] + 64'(lh_q[s][63:32]) + 64'(hl_q[s][63:32]) + 64'(mid[s][33:32]);
        p3_q[s] <= p2_q[s];
        // stage 4: quotient times modulus, low 64 bits in two halves
        qlo_m_q[s] <= 64'(q_q[s][31:0]) * 64'(modulus_i);
        qhi_m_q[s] <= 32'(64'(q_q[s][63:32]) * 64'(modulus_i));
        p4_q[s]    <= p3_q[s];
        // stage 5: remainder
        r_q[s] <= r_sub[s];
        // stage 6: final conditional subtract, or zero for a finish item
        if (c5_q.finish) begin
          res_q[s] <= '0;
        end else if (r_q[s] >= 64'(modulus_i)) begin
          res_q[s] <= 32'(r_q[s] - 64'(modulus_i));
        end else begin
          res_q[s] <= r_q[s][31:0];
        end
      end
      if (!c5_q.finish) begin
        sum_q <= '0;
      end else if (c5_q.sum >= 33'(modulus_i)) begin
        sum_q <= 32'(c5_q.sum - 33'(modulus_i));
      end else begin
        sum_q <= c5_q.sum[31:0];
      end
    end
  end

  assign out_o.valid       = c6_v_q;
  assign out_o.result_zero = res_q[0];
  assign out_o.result_one  = res_q[1];
  assign out_o.pair_sum    = sum_q;
  assign out_o.last_out    = c6_q.last;

  // a stalled result holds its flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(c6_q.last)))
    else $error("stalled result changed");
  // finish results carry no products
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && c6_q.finish) |-> (res_q[0] == '0 && res_q[1] == '0))
    else $error("finish result carries products");
  // update results carry no pair sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && !c6_q.finish) |-> (sum_q == '0))
    else $error("update result carries a pair sum");

endmodule

// ----- design/indexed_barrett_modmul_pair.sv -----
// Indexed Barrett modular multiply pair. Takes one request per cycle unless the request
// channel stalls. A load writes one factor word into the table and gives no result; an update
// multiplies both running products by their two table factors and Barrett-reduces each; a
// finish gives the modular pair sum. Results pass the dual-port table read, which completes
// at the accepting edge, a holding register, the queue and the multiply-reduce pipeline (the
// chain of 32x32 multipliers sets its depth). Back-pressure on the result channel fills the
// four-entry queue before the request channel stalls. The user must write configuration only
// while idle; the block itself does not enforce this.
module indexed_barrett_modmul_pair #(
  parameter int unsigned TABLE_DEPTH = ibmm_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ibmm_in_if.sink     in_i,
  ibmm_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  ibmm_pkg::cfg_t  cfg_q;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  ibmm_pkg::item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus        <= 32'd2147483647;
      cfg_q.barrett_factor <= 64'd8589934596;
      cfg_q.elim_mask      <= 12'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ibmm_pkg::CFG_MODULUS: cfg_q.modulus        <= cfg_data_i[31:0];
        ibmm_pkg::CFG_BARRETT: cfg_q.barrett_factor <= cfg_data_i;
        ibmm_pkg::CFG_MASK:    cfg_q.elim_mask      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  ibmm_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .elim_mask_i  (cfg_q.elim_mask),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  ibmm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  ibmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .modulus_i   (cfg_q.modulus),
    .barrett_i   (cfg_q.barrett_factor),
    .out_o       (out_o)
  );

endmodule
